// File: rtl/tldrp_pkg.sv
// ----------------------------------------------------------------------------
// tldrp_pkg: shared types and constants of the record parser
// Holds the configuration layout, the register indexes, the token that the
// front end hands to the back end, and the result codes.
// ----------------------------------------------------------------------------
package tldrp_pkg;

   // Fixed field widths.
   localparam int BYTE_WIDTH      = 8;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 8;
   localparam int STATUS_WIDTH    = 2;
   localparam int SECONDS_WIDTH   = 41;
   localparam int CLASS_WIDTH     = 2;
   localparam int RSP_DATA_WIDTH  = 48;

   // Depth of the queue between the front and back ends.
   localparam int QUEUE_DEPTH = 4;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SECTION_DELIM = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OPTION_DELIM  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIME_SECTION  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIME_OPTION   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEV_SECTION   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEV_OPTION    = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEVICE_MODE   = 3'd6;

   // Result status codes.
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_NO_TIME   = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_BAD_TIME  = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_NO_DEVICE = 2'd3;

   // Device classes.
   localparam logic [CLASS_WIDTH-1:0] CLASS_NONE   = 2'd0;
   localparam logic [CLASS_WIDTH-1:0] CLASS_PC     = 2'd1;
   localparam logic [CLASS_WIDTH-1:0] CLASS_MOBILE = 2'd2;

   // Device name prefixes that mean a desktop client ("pc" and "na").
   localparam logic [15:0] PREFIX_PC = 16'h7063;
   localparam logic [15:0] PREFIX_NA = 16'h6e61;

   // Milliseconds per second.
   localparam int MILLIS_PER_SECOND = 1000;

   typedef struct packed {
      logic [7:0] section_delim;
      logic [7:0] option_delim;
      logic [7:0] time_section;
      logic [7:0] time_option;
      logic [7:0] dev_section;
      logic [7:0] dev_option;
      logic       device_mode;
   } tldrp_cfg_type;

   localparam tldrp_cfg_type CFG_RESET = '{
      section_delim: 8'h01,
      option_delim:  8'h02,
      time_section:  8'd1,
      time_option:   8'd10,
      dev_section:   8'd6,
      dev_option:    8'd0,
      device_mode:   1'b1
   };

   // One classified record byte.
   typedef struct packed {
      logic [BYTE_WIDTH-1:0] data;
      logic                  is_opt;
      logic                  time_hit;
      logic                  dev_hit;
      logic                  last;
   } tldrp_token_type;

endpackage

// File: rtl/tldrp_front.sv
// ----------------------------------------------------------------------------
// tldrp_front: byte classifier and field locator
// Splits the byte stream at the section and option delimiters, keeps the
// section and option counters, and tags each byte with whether it lies
// inside the time option or the device option.
// ----------------------------------------------------------------------------
module tldrp_front
   import tldrp_pkg::*;
#(
   parameter int INDEX_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tldrp_cfg_type         cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [BYTE_WIDTH-1:0] in_data,
   input  logic                  in_last,
   input  logic                  queue_full,
   output logic                  push,
   output tldrp_token_type       token
);

   // Counters reach 2^INDEX_WIDTH and then hold.
   localparam int CNT_W = INDEX_WIDTH + 1;
   localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

   logic [CNT_W-1:0] sec_cnt_ff, sec_cnt_in;
   logic [CNT_W-1:0] opt_cnt_ff, opt_cnt_in;
   logic             is_sec;
   logic             is_opt;
   logic             time_match;
   logic             dev_match;

   assign in_ready = !queue_full;
   assign push     = in_valid && in_ready;

   // Delimiter decode; the section delimiter wins when both are equal.
   assign is_sec = (in_data == cfg.section_delim);
   assign is_opt = !is_sec && (in_data == cfg.option_delim);

   // Position compare against the configured field indexes.
   assign time_match = (CMP_W'(sec_cnt_ff) == CMP_W'(cfg.time_section)) &&
                       (CMP_W'(opt_cnt_ff) == CMP_W'(cfg.time_option));
   assign dev_match  = (CMP_W'(sec_cnt_ff) == CMP_W'(cfg.dev_section)) &&
                       (CMP_W'(opt_cnt_ff) == CMP_W'(cfg.dev_option));

   always_comb begin
      token.data     = in_data;
      token.is_opt   = is_opt;
      token.time_hit = !is_sec && time_match;
      token.dev_hit  = !is_sec && dev_match;
      token.last     = in_last;
   end

   // Counter update for each accepted beat; the record end clears both.
   always_comb begin
      sec_cnt_in = sec_cnt_ff;
      opt_cnt_in = opt_cnt_ff;
      if (push) begin
         if (in_last) begin
            sec_cnt_in = '0;
            opt_cnt_in = '0;
         end else if (is_sec) begin
            if (!sec_cnt_ff[CNT_W-1]) begin
               sec_cnt_in = sec_cnt_ff + 1'b1;
            end
            opt_cnt_in = '0;
         end else if (is_opt) begin
            if (!opt_cnt_ff[CNT_W-1]) begin
               opt_cnt_in = opt_cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_cnt_ff <= '0;
         opt_cnt_ff <= '0;
      end else begin
         sec_cnt_ff <= sec_cnt_in;
         opt_cnt_ff <= opt_cnt_in;
      end
   end

endmodule

// File: rtl/tldrp_queue.sv
// ----------------------------------------------------------------------------
// tldrp_queue: token queue between front and back end
// A small first-in first-out buffer of classified bytes so that the front
// end keeps taking beats while the back end waits on the result channel.
// ----------------------------------------------------------------------------
module tldrp_queue
   import tldrp_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  tldrp_token_type push_token,
   output logic            full,
   input  logic            pop,
   output logic            head_valid,
   output tldrp_token_type head_token
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tldrp_token_type  entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_token = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage; no reset needed for payload.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

// File: rtl/tldrp_back.sv
// ----------------------------------------------------------------------------
// tldrp_back: time parser, device classifier and result register
// Consumes classified bytes, parses the millisecond count while keeping it
// split into whole seconds and a remainder, classifies the device option,
// and builds one status result at each record end.
// ----------------------------------------------------------------------------
module tldrp_back
   import tldrp_pkg::*;
#(
   parameter int MILLIS_WIDTH = 50
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     device_mode,
   input  logic                     head_valid,
   input  tldrp_token_type          head_token,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [STATUS_WIDTH-1:0]  rsp_status,
   output logic [SECONDS_WIDTH-1:0] rsp_seconds,
   output logic [CLASS_WIDTH-1:0]   rsp_class
);

   // Quotient width: 2^MILLIS_WIDTH / 1000 stays below 2^(MILLIS_WIDTH-9).
   localparam int QUOT_W = MILLIS_WIDTH - 9;
   localparam int EXT_W  = MILLIS_WIDTH + 4;
   localparam int QEXT_W = QUOT_W + 4;
   localparam logic [MILLIS_WIDTH-1:0] MILLIS_MAX     = '1;
   localparam logic [MILLIS_WIDTH-1:0] QUOT_MAX_FULL  = MILLIS_MAX / MILLIS_PER_SECOND;
   localparam logic [QUOT_W-1:0]       QUOT_MAX       = QUOT_MAX_FULL[QUOT_W-1:0];
   localparam logic [MILLIS_WIDTH-1:0] REM_MAX_FULL   = MILLIS_MAX % MILLIS_PER_SECOND;
   localparam logic [9:0]              REM_MAX        = REM_MAX_FULL[9:0];

   typedef enum logic [2:0] {
      TIME_SKIP    = 3'b001,
      TIME_DIGITS  = 3'b010,
      TIME_STOPPED = 3'b100
   } time_phase_type;

   typedef enum logic [3:0] {
      DEV_NOT_SEEN = 4'b0001,
      DEV_EMPTY    = 4'b0010,
      DEV_ONE      = 4'b0100,
      DEV_TWO      = 4'b1000
   } dev_phase_type;

   time_phase_type          tphase_ff, tphase_in, tphase_n;
   dev_phase_type           dphase_ff, dphase_in, dphase_n, dphase_eff;
   logic                    found_ff, found_in, found_n;
   logic                    neg_ff, neg_in, neg_n;
   logic [MILLIS_WIDTH-1:0] acc_ff, acc_in, acc_n;
   logic [QUOT_W-1:0]       quot_ff, quot_in, quot_n;
   logic [9:0]              rem_ff, rem_in, rem_n;
   logic [15:0]             prefix_ff, prefix_in, prefix_n;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;
   logic [SECONDS_WIDTH-1:0] seconds_ff, seconds_in;
   logic [CLASS_WIDTH-1:0]  class_ff, class_in;

   logic                    out_free;
   logic                    finish;
   logic [7:0]              data;
   logic                    is_digit;
   logic                    is_space;
   logic [3:0]              digit;
   logic                    add_en;
   logic [EXT_W-1:0]        acc_ext;
   logic [EXT_W-1:0]        acc_mul;
   logic                    acc_ovf;
   logic [13:0]             rem_mul;
   logic [3:0]              carry;
   logic [13:0]             carry_millis;
   logic [QEXT_W-1:0]       quot_ext;
   logic [QEXT_W-1:0]       quot_mul;

   // A record-end byte waits until the result register is free.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop      = head_valid && (!head_token.last || out_free);
   assign finish   = pop && head_token.last;

   assign data     = head_token.data;
   assign is_digit = (data >= 8'h30) && (data <= 8'h39);
   assign is_space = data inside {8'h20, [8'h09:8'h0d]};
   assign digit    = 4'(data - 8'h30);

   // Saturation check on acc * 10 + digit.
   assign acc_ext = EXT_W'(acc_ff);
   assign acc_mul = (acc_ext << 3) + (acc_ext << 1) + EXT_W'(digit);
   assign acc_ovf = |acc_mul[EXT_W-1:MILLIS_WIDTH];

   // Remainder step: rem * 10 + digit, split into a carry of seconds.
   assign rem_mul = (14'(rem_ff) << 3) + (14'(rem_ff) << 1) + 14'(digit);

   always_comb begin
      carry        = '0;
      carry_millis = '0;
      for (int k = 1; k < 10; k++) begin
         if (rem_mul >= 14'(k * MILLIS_PER_SECOND)) begin
            carry        = 4'(k);
            carry_millis = 14'(k * MILLIS_PER_SECOND);
         end
      end
   end

   assign quot_ext = QEXT_W'(quot_ff);
   assign quot_mul = (quot_ext << 3) + (quot_ext << 1) + QEXT_W'(carry);

   // Time option parser.
   always_comb begin
      tphase_n = tphase_ff;
      neg_n    = neg_ff;
      found_n  = found_ff;
      add_en   = 1'b0;
      if (pop && head_token.time_hit) begin
         found_n = 1'b1;
         if (!head_token.is_opt) begin
            case (tphase_ff)
               TIME_SKIP: begin
                  if (is_space) begin
                     tphase_n = TIME_SKIP;
                  end else if (data == 8'h2b) begin
                     tphase_n = TIME_DIGITS;
                  end else if (data == 8'h2d) begin
                     neg_n    = 1'b1;
                     tphase_n = TIME_DIGITS;
                  end else if (is_digit) begin
                     add_en   = 1'b1;
                     tphase_n = TIME_DIGITS;
                  end else begin
                     tphase_n = TIME_STOPPED;
                  end
               end
               TIME_DIGITS: begin
                  if (is_digit) begin
                     add_en = 1'b1;
                  end else begin
                     tphase_n = TIME_STOPPED;
                  end
               end
               default: begin
                  tphase_n = tphase_ff;
               end
            endcase
         end
      end
   end

   // Accumulator kept both as a whole count and as seconds plus remainder.
   always_comb begin
      acc_n  = acc_ff;
      quot_n = quot_ff;
      rem_n  = rem_ff;
      if (add_en) begin
         if (acc_ovf) begin
            acc_n  = MILLIS_MAX;
            quot_n = QUOT_MAX;
            rem_n  = REM_MAX;
         end else begin
            acc_n  = acc_mul[MILLIS_WIDTH-1:0];
            quot_n = quot_mul[QUOT_W-1:0];
            rem_n  = 10'(rem_mul - carry_millis);
         end
      end
   end

   // Device option capture: first two bytes, or empty.
   always_comb begin
      dphase_eff = (dphase_ff == DEV_NOT_SEEN) ? DEV_EMPTY : dphase_ff;
      dphase_n   = dphase_ff;
      prefix_n   = prefix_ff;
      if (pop && head_token.dev_hit) begin
         dphase_n = dphase_eff;
         if (!head_token.is_opt) begin
            case (dphase_eff)
               DEV_EMPTY: begin
                  prefix_n = {data, 8'h00};
                  dphase_n = DEV_ONE;
               end
               DEV_ONE: begin
                  prefix_n = {prefix_ff[15:8], data};
                  dphase_n = DEV_TWO;
               end
               default: begin
                  dphase_n = dphase_eff;
               end
            endcase
         end
      end
   end

   // Result at the record end.
   always_comb begin
      status_in  = status_ff;
      seconds_in = seconds_ff;
      class_in   = class_ff;
      if (finish) begin
         seconds_in = '0;
         class_in   = CLASS_NONE;
         if (!found_n) begin
            status_in = STATUS_NO_TIME;
         end else if (neg_n || (quot_n == '0)) begin
            status_in = STATUS_BAD_TIME;
         end else if (device_mode && (dphase_n == DEV_NOT_SEEN)) begin
            status_in = STATUS_NO_DEVICE;
         end else begin
            status_in  = STATUS_OK;
            seconds_in = SECONDS_WIDTH'(quot_n);
            if (device_mode) begin
               if (dphase_n == DEV_EMPTY) begin
                  class_in = CLASS_PC;
               end else if ((dphase_n == DEV_TWO) &&
                            ((prefix_n == PREFIX_PC) || (prefix_n == PREFIX_NA))) begin
                  class_in = CLASS_PC;
               end else begin
                  class_in = CLASS_MOBILE;
               end
            end
         end
      end
   end

   // Record state clears after its last byte.
   always_comb begin
      if (finish) begin
         tphase_in = TIME_SKIP;
         dphase_in = DEV_NOT_SEEN;
         found_in  = 1'b0;
         neg_in    = 1'b0;
         acc_in    = '0;
         quot_in   = '0;
         rem_in    = '0;
         prefix_in = '0;
      end else begin
         tphase_in = tphase_n;
         dphase_in = dphase_n;
         found_in  = found_n;
         neg_in    = neg_n;
         acc_in    = acc_n;
         quot_in   = quot_n;
         rem_in    = rem_n;
         prefix_in = prefix_n;
      end
   end

   assign rsp_valid_in = finish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         tphase_ff    <= TIME_SKIP;
         dphase_ff    <= DEV_NOT_SEEN;
         found_ff     <= 1'b0;
         neg_ff       <= 1'b0;
         acc_ff       <= '0;
         quot_ff      <= '0;
         rem_ff       <= '0;
         prefix_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tphase_ff    <= tphase_in;
         dphase_ff    <= dphase_in;
         found_ff     <= found_in;
         neg_ff       <= neg_in;
         acc_ff       <= acc_in;
         quot_ff      <= quot_in;
         rem_ff       <= rem_in;
         prefix_ff    <= prefix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      seconds_ff <= seconds_in;
      class_ff   <= class_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = status_ff;
   assign rsp_seconds = seconds_ff;
   assign rsp_class   = class_ff;

   // A failed record carries no seconds and no device class.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff != STATUS_OK)) |->
         ((seconds_ff == '0) && (class_ff == CLASS_NONE)))
      else $error("failed record result carries payload");

   // A sign is only recorded once the parser has left whitespace skipping.
   assert property (@(posedge clock) disable iff (reset)
      neg_ff |-> (tphase_ff != TIME_SKIP))
      else $error("sign set while still skipping whitespace");

   // The remainder of the millisecond count stays below one second.
   assert property (@(posedge clock) disable iff (reset)
      rem_ff < 10'd1000)
      else $error("millisecond remainder out of range");

   // After a record end the parse state starts over.
   assert property (@(posedge clock) disable iff (reset)
      finish |=> (!found_ff && (acc_ff == '0) && (dphase_ff == DEV_NOT_SEEN)))
      else $error("record state not cleared after record end");

endmodule

// File: rtl/two_level_delimited_record_parser_core.sv
// ----------------------------------------------------------------------------
// two_level_delimited_record_parser_core: record time and device parser
// Top level: configuration registers, front end, token queue, back end.
// ----------------------------------------------------------------------------
// Record bytes enter on the req_ channel one beat per byte, req_tlast on the
// final byte. Each record gives exactly one beat on the rsp_ channel with a
// status, the time option's millisecond count in whole seconds, and the
// device class. Configuration is written through csr_we/csr_index/csr_wdata
// while no record is in flight; the user must ensure this, the block has no check.
// Throughput is one byte per clock while the queue has room. The front end
// classifies a byte in its accept cycle and writes it into a four-entry queue;
// the back end takes one byte per cycle from the queue unless a record's last
// byte waits for the result register, which is loaded from it and drives rsp_tvalid.
// The seconds value is built while digits arrive (quotient and remainder by
// 1000 updated per digit), so no divider sits at the record end.
// When rsp_tready is low, the result is held in the output register and the
// back end stops only at the next record end; the front end keeps taking
// bytes until the queue fills, then drops req_tready.
// Reset returns all configuration registers to their defaults, empties the
// queue, clears the counters and parse state, and drops rsp_tvalid.
// ----------------------------------------------------------------------------
module two_level_delimited_record_parser_core
   import tldrp_pkg::*;
#(
   parameter int INDEX_WIDTH  = 8,
   parameter int MILLIS_WIDTH = 50
) (
   input  logic                       clock,
   input  logic                       reset,
   // Record byte channel.
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [7:0] data_byte
   input  logic                       req_tlast,   // end_of_record
   // Result channel.
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0]  rsp_tdata,   // [1:0] status, [42:2] seconds,
                                                   // [44:43] device_class, rest zero
   // Configuration write port.
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   tldrp_cfg_type            cfg_ff, cfg_in;
   tldrp_token_type          push_token;
   tldrp_token_type          head_token;
   logic                     push;
   logic                     pop;
   logic                     queue_full;
   logic                     head_valid;
   logic [STATUS_WIDTH-1:0]  rsp_status;
   logic [SECONDS_WIDTH-1:0] rsp_seconds;
   logic [CLASS_WIDTH-1:0]   rsp_class;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SECTION_DELIM: cfg_in.section_delim = csr_wdata;
            CSR_OPTION_DELIM:  cfg_in.option_delim  = csr_wdata;
            CSR_TIME_SECTION:  cfg_in.time_section  = csr_wdata;
            CSR_TIME_OPTION:   cfg_in.time_option   = csr_wdata;
            CSR_DEV_SECTION:   cfg_in.dev_section   = csr_wdata;
            CSR_DEV_OPTION:    cfg_in.dev_option    = csr_wdata;
            CSR_DEVICE_MODE:   cfg_in.device_mode   = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tldrp_front #(
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_data    (req_tdata),
      .in_last    (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .token      (push_token)
   );

   tldrp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_token (head_token)
   );

   tldrp_back #(
      .MILLIS_WIDTH (MILLIS_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .device_mode (cfg_ff.device_mode),
      .head_valid  (head_valid),
      .head_token  (head_token),
      .pop         (pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_status  (rsp_status),
      .rsp_seconds (rsp_seconds),
      .rsp_class   (rsp_class)
   );

   // Result beat packing, first field in the lowest bits.
   assign rsp_tdata = {3'b000, rsp_class, rsp_seconds, rsp_status};

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for two_level_delimited_record_parser_core
// Record bytes are streamed in with random gaps and result beats are taken
// with random back-pressure. A bench-side parser tracks sections, options,
// the millisecond count and the device prefix, and predicts each record's
// status, seconds and device class, which are checked beat by beat.
// ----------------------------------------------------------------------------
module tb
   import tldrp_pkg::*;
();

   localparam int INDEX_BITS  = 8;
   localparam int MILLIS_BITS = 50;
   localparam int COUNT_LIMIT = 1 << INDEX_BITS;
   localparam logic [63:0] MILLIS_CEILING = (64'd1 << MILLIS_BITS) - 64'd1;
   localparam int SETTLE_CYCLES = 12;
   localparam int DRAIN_LIMIT   = 20000;

   typedef enum logic [1:0] {
      TIME_SKIP_BLANKS,
      TIME_IN_DIGITS,
      TIME_STOPPED
   } time_phase_type;

   typedef enum logic [1:0] {
      DEV_UNSEEN,
      DEV_EMPTY,
      DEV_ONE_BYTE,
      DEV_TWO_BYTES
   } device_phase_type;

   typedef struct {
      logic [STATUS_WIDTH-1:0]  status;
      logic [SECONDS_WIDTH-1:0] seconds;
      logic [CLASS_WIDTH-1:0]   device_class;
   } record_result_type;

   // DUT ports; the bench drives its inputs with known values from time zero.
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata = 8'h00;
   logic                      req_tlast = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_SECTION_DELIM;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = 8'h00;

   // Bench-side copy of the configuration and the per-record parse state.
   tldrp_cfg_type    cfg = CFG_RESET;
   int               sec_count;
   int               opt_count;
   time_phase_type   time_phase;
   logic             minus_seen;
   logic [63:0]      millis_count;
   logic             time_seen;
   device_phase_type device_phase;
   logic [15:0]      device_prefix;

   record_result_type pending_results[$];
   logic [7:0]        record_bytes[$];
   logic [7:0]        blank_chars[6] = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int errors = 0;
   int records_sent = 0;
   int bytes_sent = 0;
   int settings_used = 0;

   two_level_delimited_record_parser_core #(
      .INDEX_WIDTH (INDEX_BITS),
      .MILLIS_WIDTH(MILLIS_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("%0t: run did not finish in time", $time);
      $display("status: fail");
      $finish;
   end

   // Result side back-pressure.
   always @(posedge clock) begin
      rsp_tready <= (rsp_stall_pct == 0) || ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Advance the parse state by one accepted byte; on the record's last byte
   // queue its expected result and clear the state.
   task automatic parse_record_byte(input logic [7:0] b, input logic is_last);
      logic              is_sec;
      logic              is_opt;
      logic              is_digit;
      logic              is_blank;
      logic [63:0]       digit;
      record_result_type r;
      is_sec   = (b == cfg.section_delim);
      is_opt   = !is_sec && (b == cfg.option_delim);
      is_digit = (b >= "0") && (b <= "9");
      is_blank = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
      digit    = 64'(b) - 64'd48;

      if (!is_sec) begin
         // Time option: blanks, optional sign, then saturating digits.
         if (sec_count == cfg.time_section && opt_count == cfg.time_option) begin
            time_seen = 1'b1;
            if (!is_opt && time_phase != TIME_STOPPED) begin
               if (is_digit) begin
                  if (millis_count > (MILLIS_CEILING - digit) / 64'd10)
                     millis_count = MILLIS_CEILING;
                  else
                     millis_count = millis_count * 64'd10 + digit;
                  time_phase = TIME_IN_DIGITS;
               end else if (time_phase == TIME_SKIP_BLANKS && is_blank) begin
               end else if (time_phase == TIME_SKIP_BLANKS && b == "+") begin
                  time_phase = TIME_IN_DIGITS;
               end else if (time_phase == TIME_SKIP_BLANKS && b == "-") begin
                  minus_seen = 1'b1;
                  time_phase = TIME_IN_DIGITS;
               end else begin
                  time_phase = TIME_STOPPED;
               end
            end
         end
         // Device option: remember whether it was seen and its first two bytes.
         if (sec_count == cfg.dev_section && opt_count == cfg.dev_option) begin
            if (device_phase == DEV_UNSEEN)
               device_phase = DEV_EMPTY;
            if (!is_opt) begin
               if (device_phase == DEV_EMPTY) begin
                  device_prefix = {b, 8'h00};
                  device_phase  = DEV_ONE_BYTE;
               end else if (device_phase == DEV_ONE_BYTE) begin
                  device_prefix[7:0] = b;
                  device_phase       = DEV_TWO_BYTES;
               end
            end
         end
      end

      // Position counters hold at their limit.
      if (is_sec) begin
         if (sec_count < COUNT_LIMIT)
            sec_count++;
         opt_count = 0;
      end else if (is_opt) begin
         if (opt_count < COUNT_LIMIT)
            opt_count++;
      end

      if (is_last) begin
         r.seconds      = '0;
         r.device_class = CLASS_NONE;
         if (!time_seen) begin
            r.status = STATUS_NO_TIME;
         end else if (minus_seen || millis_count < 64'(MILLIS_PER_SECOND)) begin
            r.status = STATUS_BAD_TIME;
         end else if (cfg.device_mode && device_phase == DEV_UNSEEN) begin
            r.status = STATUS_NO_DEVICE;
         end else begin
            r.status  = STATUS_OK;
            r.seconds = SECONDS_WIDTH'(millis_count / 64'(MILLIS_PER_SECOND));
            if (cfg.device_mode) begin
               if (device_phase == DEV_EMPTY ||
                   (device_phase == DEV_TWO_BYTES &&
                    (device_prefix == PREFIX_PC || device_prefix == PREFIX_NA)))
                  r.device_class = CLASS_PC;
               else
                  r.device_class = CLASS_MOBILE;
            end
         end
         pending_results.push_back(r);
         sec_count     = 0;
         opt_count     = 0;
         time_phase    = TIME_SKIP_BLANKS;
         minus_seen    = 1'b0;
         millis_count  = '0;
         time_seen     = 1'b0;
         device_phase  = DEV_UNSEEN;
         device_prefix = '0;
      end
   endtask

   // Check every result beat against the oldest expected result.
   always @(negedge clock) begin
      record_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result beat with none expected, got %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[1:0] !== want.status) begin
               $display("%0t: status expected %0d got %0d", $time, want.status,
                        rsp_tdata[1:0]);
               errors++;
            end
            if (rsp_tdata[42:2] !== want.seconds) begin
               $display("%0t: seconds expected %0d got %0d", $time, want.seconds,
                        rsp_tdata[42:2]);
               errors++;
            end
            if (rsp_tdata[44:43] !== want.device_class) begin
               $display("%0t: device class expected %0d got %0d", $time,
                        want.device_class, rsp_tdata[44:43]);
               errors++;
            end
            if (rsp_tdata[RSP_DATA_WIDTH-1:45] !== '0) begin
               $display("%0t: padding expected 0 got %h", $time,
                        rsp_tdata[RSP_DATA_WIDTH-1:45]);
               errors++;
            end
         end
      end
   end

   // Send one record byte, idling first as the current phase asks.
   task automatic send_byte(input logic [7:0] b, input logic is_last);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= is_last;
      do @(negedge clock); while (!req_tready);
      parse_record_byte(b, is_last);
      bytes_sent++;
      @(posedge clock);
   endtask

   task automatic send_record();
      int n;
      n = record_bytes.size();
      for (int i = 0; i < n; i++)
         send_byte(record_bytes[i], i == n - 1);
      record_bytes.delete();
      records_sent++;
   endtask

   // Stop sending, wait for every outstanding result, then let the design settle.
   task automatic wait_idle();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_results.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time,
                  pending_results.size());
         errors += pending_results.size();
         pending_results.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [7:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic apply_config(input logic [7:0] sec_delim, input logic [7:0] opt_delim,
                               input logic [7:0] time_sec, input logic [7:0] time_opt,
                               input logic [7:0] dev_sec, input logic [7:0] dev_opt,
                               input logic mode);
      wait_idle();
      write_reg(CSR_SECTION_DELIM, sec_delim);
      write_reg(CSR_OPTION_DELIM, opt_delim);
      write_reg(CSR_TIME_SECTION, time_sec);
      write_reg(CSR_TIME_OPTION, time_opt);
      write_reg(CSR_DEV_SECTION, dev_sec);
      write_reg(CSR_DEV_OPTION, dev_opt);
      write_reg(CSR_DEVICE_MODE, {7'd0, mode});
      csr_we <= 1'b0;
      cfg.section_delim = sec_delim;
      cfg.option_delim  = opt_delim;
      cfg.time_section  = time_sec;
      cfg.time_option   = time_opt;
      cfg.dev_section   = dev_sec;
      cfg.dev_option    = dev_opt;
      cfg.device_mode   = mode;
      settings_used++;
   endtask

   task automatic push_byte(input logic [7:0] b);
      record_bytes.push_back(b);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         record_bytes.push_back(s[i]);
   endtask

   task automatic send_text(input string s);
      push_text(s);
      send_record();
   endtask

   // Content byte that cannot be mistaken for a delimiter.
   function automatic logic [7:0] plain_byte(input logic [7:0] b);
      while (b == cfg.section_delim || b == cfg.option_delim)
         b = b + 8'd1;
      return b;
   endfunction

   // Random millisecond text: optional blanks and sign, digits, maybe junk.
   task automatic add_time_text();
      int n;
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) push_byte(plain_byte(blank_chars[$urandom_range(0, 5)]));
      case ($urandom_range(0, 6))
         0: push_byte(plain_byte("+"));
         1: push_byte(plain_byte("-"));
         default: ;
      endcase
      case ($urandom_range(0, 9))
         0: n = 0;
         1: n = $urandom_range(1, 3);
         2: n = $urandom_range(15, 18);
         default: n = $urandom_range(4, 10);
      endcase
      repeat (n) push_byte(plain_byte(8'($urandom_range(48, 57))));
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) push_byte(plain_byte(8'($urandom_range(0, 255))));
   endtask

   // Random device text: desktop prefixes, empty, one byte, or other names.
   task automatic add_device_text();
      case ($urandom_range(0, 6))
         0, 1: begin
            push_byte(plain_byte("p"));
            push_byte(plain_byte("c"));
            repeat ($urandom_range(0, 3)) push_byte(plain_byte(8'($urandom_range(0, 255))));
         end
         2: begin
            push_byte(plain_byte("n"));
            push_byte(plain_byte("a"));
            repeat ($urandom_range(0, 3)) push_byte(plain_byte(8'($urandom_range(0, 255))));
         end
         3: ;
         4: push_byte(plain_byte(8'($urandom_range(0, 255))));
         default: begin
            if ($urandom_range(0, 1) == 0)
               push_byte(plain_byte("p"));
            repeat ($urandom_range(1, 4)) push_byte(plain_byte(8'($urandom_range(0, 255))));
         end
      endcase
   endtask

   // A record laid out for the current setting, now and then cut short or
   // with the wanted options left out.
   task automatic build_wellformed_record();
      int last_sec;
      int n_opt;
      int keep;
      last_sec = (cfg.time_section > cfg.dev_section) ? cfg.time_section : cfg.dev_section;
      last_sec += $urandom_range(0, 1);
      for (int s = 0; s <= last_sec; s++) begin
         n_opt = $urandom_range(1, 3);
         if (s == cfg.time_section && n_opt <= cfg.time_option)
            n_opt = cfg.time_option + 1;
         if (s == cfg.dev_section && n_opt <= cfg.dev_option)
            n_opt = cfg.dev_option + 1;
         if ($urandom_range(0, 7) == 0)
            n_opt = $urandom_range(0, n_opt);
         for (int o = 0; o < n_opt; o++) begin
            if (o > 0)
               push_byte(cfg.option_delim);
            if (s == cfg.time_section && o == cfg.time_option)
               add_time_text();
            else if (s == cfg.dev_section && o == cfg.dev_option)
               add_device_text();
            else
               repeat ($urandom_range(0, 3)) push_byte(plain_byte(8'($urandom_range(97, 122))));
         end
         if (s < last_sec)
            push_byte(cfg.section_delim);
      end
      if ($urandom_range(0, 9) == 0 && record_bytes.size() > 1) begin
         keep = $urandom_range(1, record_bytes.size() - 1);
         while (record_bytes.size() > keep)
            void'(record_bytes.pop_back());
      end
      if (record_bytes.size() == 0)
         push_byte(plain_byte("z"));
   endtask

   // Short record of delimiters, digits and arbitrary bytes.
   task automatic build_noise_record();
      repeat ($urandom_range(1, 12)) begin
         case ($urandom_range(0, 3))
            0: push_byte(cfg.section_delim);
            1: push_byte(cfg.option_delim);
            2: push_byte(8'($urandom_range(48, 57)));
            default: push_byte(8'($urandom_range(0, 255)));
         endcase
      end
   endtask

   function automatic logic [7:0] random_delim();
      case ($urandom_range(0, 3))
         0: return 8'h01;
         1: return ",";
         2: return "|";
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Records laid out for the reset setting.
   task automatic test_reset_layout();
      push_text("ab");
      push_byte(CFG_RESET.section_delim);
      push_text("o0");
      repeat (10) push_byte(CFG_RESET.option_delim);
      push_text(" 1700000000123");
      repeat (5) push_byte(CFG_RESET.section_delim);
      push_text("pcweb");
      send_record();
      send_text("ab");
   endtask

   // Millisecond parsing: blanks, signs, bounds, saturation, stops, absence.
   task automatic test_time_field();
      apply_config(",", ":", 8'd0, 8'd1, 8'd1, 8'd0, 1'b1);
      send_text("x: \011+12345,pcweb");
      send_text("x:-5000,pc");
      send_text("x:999,na");
      send_text("x:1000,pc");
      send_text("x:99999999999999999999,pc");
      send_text("x:\012\013\014\01512000abc9,pc");
      send_text("x:,pc");
      send_text("x::,pc");
      send_text("x");
      send_text("x:5000");
      push_text("x:");
      push_byte(8'h00);
      send_text("3000,pc");
      send_text("x:   ,pc");
   endtask

   // Device classification, a missing device option, and timestamp-only mode.
   task automatic test_device_field();
      send_text("x:2000,na1");
      send_text("x:2000,:");
      send_text("x:2000,m");
      send_text("x:2000,nb");
      send_text("x:2000,");
      apply_config(",", ":", 8'd0, 8'd1, 8'd1, 8'd0, 1'b0);
      send_text("x:2000,pc");
      send_text("x:4000");
   endtask

   // Equal delimiters, delimiter bytes at 0x00 and 0xff, and a section index
   // of 255, one below the value at which the section counter holds.
   task automatic test_delimiter_extremes();
      apply_config(",", ",", 8'd1, 8'd0, 8'd0, 8'd0, 1'b1);
      send_text("pc,7000");
      apply_config(8'h00, 8'hff, 8'd0, 8'd1, 8'd0, 8'd0, 1'b1);
      push_text("na");
      push_byte(8'hff);
      send_text("4000");
      apply_config(8'hff, 8'h00, 8'd0, 8'd1, 8'd0, 8'd0, 1'b1);
      push_text("mob");
      push_byte(8'h00);
      send_text("6000");

      apply_config(",", ":", 8'd255, 8'd0, 8'd0, 8'd0, 1'b1);
      push_text("pc");
      repeat (255) push_byte(",");
      send_text("9000");
   endtask

   // Random settings and records under one idle and stall mix.
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int byte_goal, input int record_goal);
      logic [7:0] sd;
      logic [7:0] od;
      int         first_byte;
      int         first_record;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      first_byte    = bytes_sent;
      first_record  = records_sent;
      while (bytes_sent - first_byte < byte_goal || records_sent - first_record < record_goal)
      begin
         sd = random_delim();
         od = sd;
         if ($urandom_range(0, 19) != 0)
            while (od == sd) od = random_delim();
         apply_config(sd, od, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                      8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                      1'($urandom_range(0, 1)));
         repeat ($urandom_range(2, 3)) begin
            if ($urandom_range(0, 9) == 0)
               build_noise_record();
            else
               build_wellformed_record();
            send_record();
         end
      end
   endtask

   initial begin
      sec_count     = 0;
      opt_count     = 0;
      time_phase    = TIME_SKIP_BLANKS;
      minus_seen    = 1'b0;
      millis_count  = '0;
      time_seen     = 1'b0;
      device_phase  = DEV_UNSEEN;
      device_prefix = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_layout();
      test_time_field();
      test_device_field();
      test_delimiter_extremes();
      test_random_traffic(0, 0, 50, 2);
      test_random_traffic(80, 0, 50, 2);
      test_random_traffic(0, 80, 50, 2);
      test_random_traffic(30, 30, 50, 2);
      wait_idle();

      $display("Covered %0d records in %0d bytes under %0d register settings,", records_sent,
               bytes_sent, settings_used);
      $display("with sender gaps and result stalls mixed in four phases.");
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
